>>> design/drs_pkg.sv
// Shared types and constants for the disk request scheduler.
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;

	localparam int MAX_REQ  = 32;
	localparam int TRACK_W  = 16;
	localparam int IDX_W    = $clog2(MAX_REQ);
	localparam int CNT_W    = $clog2(MAX_REQ + 1);
	localparam int DIST_W   = 22;
	localparam int TCNT_W   = TRACK_W + 1;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// algorithm register codes
	localparam logic [1:0] ALG_SSTF  = 2'd0;
	localparam logic [1:0] ALG_SCAN  = 2'd1;
	localparam logic [1:0] ALG_CLOOK = 2'd2;

	// register indexes on the config port
	localparam logic [1:0] REG_ALG   = 2'd0;
	localparam logic [1:0] REG_DIR   = 2'd1;
	localparam logic [1:0] REG_TCNT  = 2'd2;
	localparam logic [1:0] REG_SHEAD = 2'd3;

	typedef enum logic [1:0] {
		KEY_DIST = 2'd0,
		KEY_MIN  = 2'd1,
		KEY_MAX  = 2'd2
	} key_mode_t;

	typedef enum logic [1:0] {
		GRP_ALL   = 2'd0,
		GRP_UPPER = 2'd1,
		GRP_LOWER = 2'd2
	} grp_t;

	typedef struct packed {
		logic      clr;
		logic      vld;
		key_mode_t mode;
		grp_t      grp;
	} pick_ctl_t;

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

endpackage
`default_nettype wire

>>> design/drs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module drs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/drs_pick.sv
// Shared compare unit: keeps the best eligible candidate seen during one store pass.
`timescale 1ns / 1ps
`default_nettype none
module drs_pick (
	input  wire                             clk,
	input  wire                             arst_n,
	input  drs_pkg::pick_ctl_t              ctl,
	input  wire [drs_pkg::IDX_W-1:0]        cand_idx,
	input  wire [drs_pkg::TRACK_W-1:0]      cand_val,
	input  wire                             cand_served,
	input  wire [drs_pkg::TRACK_W-1:0]      head,
	input  wire [drs_pkg::TRACK_W-1:0]      h0,
	output logic                            found,
	output logic [drs_pkg::IDX_W-1:0]       best_idx,
	output logic [drs_pkg::TRACK_W-1:0]     best_val
);

	logic                          found_q;
	logic [drs_pkg::TRACK_W-1:0]   best_key_q;
	logic [drs_pkg::IDX_W-1:0]     best_idx_q;
	logic [drs_pkg::TRACK_W-1:0]   best_val_q;
	logic [drs_pkg::TRACK_W-1:0]   key;
	logic                          in_grp;
	logic                          take;

	always_comb begin
		case (ctl.mode)
			drs_pkg::KEY_DIST: key = (cand_val > head) ? cand_val - head : head - cand_val;
			drs_pkg::KEY_MIN:  key = cand_val;
			drs_pkg::KEY_MAX:  key = ~cand_val;
			default:           key = cand_val;
		endcase
		case (ctl.grp)
			drs_pkg::GRP_ALL:   in_grp = 1'b1;
			drs_pkg::GRP_UPPER: in_grp = cand_val > h0;
			drs_pkg::GRP_LOWER: in_grp = cand_val <= h0;
			default:            in_grp = 1'b0;
		endcase
	end

	// strict less keeps the lowest index on a tie
	assign take = ctl.vld && !cand_served && in_grp && (!found_q || key < best_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_idx_q <= cand_idx;
			best_val_q <= cand_val;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_val = best_val_q;

endmodule
`default_nettype wire

>>> design/disk_request_scheduler_unit.sv
// Disk request scheduler top level: request store, sequencer, config port, output register.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid/s_tready         tdata=request_track, tlast=last_request
//  m_*      out  m_tvalid/m_tready         tdata=position,distance; tuser=disk end; tlast
//  apb      in   psel&penable&pwrite       algorithm, direction, track_count, start_head
//
//  A non-final request is written into the store. The final request starts the walk: each
//  emitted position (disk end included) costs one pass over the store through the shared
//  compare unit, plus one pass when a C-LOOK batch crosses to its second side; s_tready
//  is low until the last beat is in the output register. A full output register holds
//  the sequencer in its decide step. Reset clears control state and sets config to defaults.
`timescale 1ns / 1ps
`default_nettype none
module disk_request_scheduler_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] request_track
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [15:0] served_position, [37:16] distance_so_far, pad
	output logic        m_tuser,   // [0] is_disk_end
	output logic        m_tlast
);

	localparam int TW = drs_pkg::TRACK_W;
	localparam int CW = drs_pkg::CNT_W;
	localparam int IW = drs_pkg::IDX_W;
	localparam int DW = drs_pkg::DIST_W;
	localparam int NW = drs_pkg::TCNT_W;
	localparam logic [NW-1:0] SPAN = {1'b1, {TW{1'b0}}};

	// config registers
	logic [1:0]    alg_q;
	logic          dir_q;
	logic [NW-1:0] tcnt_q;
	logic [TW-1:0] shead_q;

	// sequencer state
	drs_pkg::state_t          state_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            srv_cnt_q;
	logic [IW-1:0]            scan_q;
	logic                     phase_q;
	logic [drs_pkg::MAX_REQ-1:0] served_q;
	logic [TW-1:0]            head_q;
	logic [TW-1:0]            h0_q;
	logic [DW-1:0]            total_q;
	logic                     rd_vld_s1;
	logic [IW-1:0]            idx_s1;

	// output register
	logic          m_tvalid_q;
	logic [TW-1:0] o_pos_q;
	logic [DW-1:0] o_dist_q;
	logic          o_end_q;
	logic          o_last_q;

	logic               cfg_wr;
	logic               s_acc;
	logic               store_we;
	logic [TW-1:0]      rd_data;
	logic               found;
	logic [IW-1:0]      best_idx;
	logic [TW-1:0]      best_val;
	drs_pkg::pick_ctl_t pick_ctl;
	logic               is_scan;
	logic               is_clook;
	logic               is_sweep;
	logic               out_free;
	logic [TW-1:0]      end_pos;
	logic [TW-1:0]      next_pos;
	logic [TW-1:0]      step_d;
	logic [DW:0]        sum_w;
	logic [DW-1:0]      total_new;
	logic               req_last;
	logic               end_last;
	logic               scan_done;
	logic               out_load;
	logic               out_last_d;
	logic               go_search;

	assign is_scan  = alg_q == drs_pkg::ALG_SCAN;
	assign is_clook = alg_q == drs_pkg::ALG_CLOOK;
	assign is_sweep = is_scan || is_clook;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q   <= drs_pkg::ALG_SSTF;
			dir_q   <= 1'b1;
			tcnt_q  <= SPAN;
			shead_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				drs_pkg::REG_ALG:   alg_q   <= pwdata[1:0];
				drs_pkg::REG_DIR:   dir_q   <= pwdata[0];
				drs_pkg::REG_TCNT:  tcnt_q  <= pwdata[NW-1:0];
				drs_pkg::REG_SHEAD: shead_q <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			drs_pkg::REG_ALG:   prdata = {30'd0, alg_q};
			drs_pkg::REG_DIR:   prdata = {31'd0, dir_q};
			drs_pkg::REG_TCNT:  prdata = {{(32-NW){1'b0}}, tcnt_q};
			drs_pkg::REG_SHEAD: prdata = {{(32-TW){1'b0}}, shead_q};
			default:            prdata = '0;
		endcase
	end

	// ---------------- request store ----------------
	assign s_tready = state_q == drs_pkg::ST_LOAD;
	assign s_acc    = s_tvalid && s_tready;
	assign store_we = s_acc && (cnt_q < CW'(drs_pkg::MAX_REQ));

	drs_ram #(
		.WIDTH(TW),
		.DEPTH(drs_pkg::MAX_REQ)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(s_tdata),
		.raddr(scan_q),
		.rdata(rd_data)
	);

	// ---------------- shared compare unit ----------------
	always_comb begin
		pick_ctl.vld = rd_vld_s1;
		pick_ctl.clr = go_search;
		if (!is_sweep) begin
			pick_ctl.mode = drs_pkg::KEY_DIST;
			pick_ctl.grp  = drs_pkg::GRP_ALL;
		end else if (!phase_q) begin
			pick_ctl.mode = dir_q ? drs_pkg::KEY_MIN : drs_pkg::KEY_MAX;
			pick_ctl.grp  = dir_q ? drs_pkg::GRP_UPPER : drs_pkg::GRP_LOWER;
		end else if (dir_q) begin
			pick_ctl.mode = is_scan ? drs_pkg::KEY_MAX : drs_pkg::KEY_MIN;
			pick_ctl.grp  = drs_pkg::GRP_LOWER;
		end else begin
			pick_ctl.mode = is_scan ? drs_pkg::KEY_MIN : drs_pkg::KEY_MAX;
			pick_ctl.grp  = drs_pkg::GRP_UPPER;
		end
	end

	drs_pick u_pick (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (pick_ctl),
		.cand_idx   (idx_s1),
		.cand_val   (rd_data),
		.cand_served(served_q[idx_s1]),
		.head       (head_q),
		.h0         (h0_q),
		.found      (found),
		.best_idx   (best_idx),
		.best_val   (best_val)
	);

	// ---------------- move and distance ----------------
	always_comb begin
		if (!dir_q || tcnt_q == '0) begin
			end_pos = '0;
		end else if (tcnt_q > SPAN) begin
			end_pos = {TW{1'b1}};
		end else begin
			end_pos = TW'(tcnt_q - NW'(1));
		end
	end

	assign next_pos  = found ? best_val : end_pos;
	assign step_d    = (next_pos > head_q) ? next_pos - head_q : head_q - next_pos;
	assign sum_w     = {1'b0, total_q} + {{(DW+1-TW){1'b0}}, step_d};
	assign total_new = sum_w[DW] ? drs_pkg::DIST_MAX : sum_w[DW-1:0];

	// a SCAN first side is never the end: the disk end still follows
	assign req_last  = (srv_cnt_q + CW'(1) == cnt_q) && !(is_scan && !phase_q);
	assign end_last  = srv_cnt_q == cnt_q;
	assign scan_done = {1'b0, scan_q} == cnt_q - CW'(1);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		out_load   = 1'b0;
		out_last_d = 1'b0;
		go_search  = 1'b0;
		if (s_acc && s_tlast) begin
			go_search = 1'b1;
		end
		if (state_q == drs_pkg::ST_DECIDE) begin
			if (found) begin
				out_load   = out_free;
				out_last_d = req_last;
				go_search  = out_free && !req_last;
			end else if (is_scan && !phase_q) begin
				out_load   = out_free;
				out_last_d = end_last;
				go_search  = out_free && !end_last;
			end else if (is_clook && !phase_q) begin
				go_search = 1'b1;
			end
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= drs_pkg::ST_LOAD;
			cnt_q     <= '0;
			srv_cnt_q <= '0;
			scan_q    <= '0;
			phase_q   <= 1'b0;
			served_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == drs_pkg::ST_SEARCH;
			case (state_q)
				drs_pkg::ST_LOAD: begin
					if (store_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (s_acc && s_tlast) begin
						srv_cnt_q <= '0;
						phase_q   <= 1'b0;
						served_q  <= '0;
						scan_q    <= '0;
						state_q   <= drs_pkg::ST_SEARCH;
					end
				end
				drs_pkg::ST_SEARCH: begin
					if (scan_done) begin
						state_q <= drs_pkg::ST_DRAIN;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				drs_pkg::ST_DRAIN: begin
					state_q <= drs_pkg::ST_DECIDE;
				end
				drs_pkg::ST_DECIDE: begin
					if (found) begin
						if (out_free) begin
							served_q[best_idx] <= 1'b1;
							srv_cnt_q <= srv_cnt_q + CW'(1);
						end
					end else if (out_free || !is_scan) begin
						// the SCAN disk end beat must be taken before the side flips
						phase_q <= 1'b1;
					end
					if (go_search) begin
						scan_q  <= '0;
						state_q <= drs_pkg::ST_SEARCH;
					end else if (out_load || (!found && !(is_sweep && !phase_q))) begin
						// batch finished (or nothing left to serve)
						cnt_q   <= '0;
						state_q <= drs_pkg::ST_LOAD;
					end
				end
				default: state_q <= drs_pkg::ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (s_acc && s_tlast) begin
			head_q  <= shead_q;
			h0_q    <= shead_q;
			total_q <= '0;
		end else if (out_load) begin
			head_q  <= next_pos;
			total_q <= total_new;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_pos_q  <= next_pos;
			o_dist_q <= total_new;
			o_end_q  <= !found;
			o_last_q <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, o_dist_q, o_pos_q};
	assign m_tuser  = o_end_q;
	assign m_tlast  = o_last_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(drs_pkg::MAX_REQ))
		else $error("request count above store depth");

	a_srv_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != drs_pkg::ST_LOAD) |-> (srv_cnt_q <= cnt_q))
		else $error("more requests served than loaded");

	a_sstf_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drs_pkg::ST_DECIDE && !is_sweep) |-> found)
		else $error("nearest-first pass found no unserved request");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == drs_pkg::ST_LOAD && cnt_q == '0))
		else $error("final beat did not return to loading");
`endif

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the disk request scheduler: stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps
module tb_top;

	localparam int IDLE_LIMIT   = 6000;
	localparam int SETTLE_TICKS = 80;
	localparam int RAND_ITEMS   = 180;

	typedef struct {
		logic [15:0] trk;
		logic        fin;
	} req_beat_t;

	typedef struct {
		logic [15:0]                pos;
		logic                       at_end;
		logic [drs_pkg::DIST_W-1:0] seek;
		logic                       last;
	} visit_t;

	typedef enum logic [1:0] {
		RDY_FULL,
		RDY_COIN,
		RDY_SPARSE
	} rdy_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	disk_request_scheduler_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// bench copy of the config registers, reset values
	logic [1:0]        cfg_alg  = drs_pkg::ALG_SSTF;
	logic              cfg_dir  = 1'b1;
	logic [16:0]       cfg_tcnt = 17'd65536;
	logic [15:0]       cfg_head = '0;

	// scheduler shadow state
	logic [15:0]                req_store [drs_pkg::MAX_REQ];
	int                         req_cnt = 0;
	logic [15:0]                head_pos = '0;
	logic [drs_pkg::DIST_W-1:0] seek_sum = '0;

	req_beat_t         req_queue [$];
	visit_t            expected_visits [$];
	visit_t            exp_v;

	int                pushed_cnt = 0;
	int                accepted_cnt = 0;
	int                errors = 0;
	int                idle_cycles = 0;
	int                gap_left = 0;
	int                burst_left = 1;
	int                rdy_hold = 0;
	rdy_mode_t         rdy_mode = RDY_FULL;
	req_beat_t         nxt;

	// move the head, add the seek, and queue the visit it produces
	function automatic void move_head(input logic [15:0] pos, input logic at_end);
		logic [16:0]              d;
		logic [drs_pkg::DIST_W:0] sum;
		visit_t                   v;
		d = (pos > head_pos) ? pos - head_pos : head_pos - pos;
		sum = seek_sum + d;
		seek_sum = (sum > drs_pkg::DIST_MAX) ? drs_pkg::DIST_MAX : sum[drs_pkg::DIST_W-1:0];
		head_pos = pos;
		v.pos = pos;
		v.at_end = at_end;
		v.seek = seek_sum;
		v.last = 1'b0;
		expected_visits.push_back(v);
	endfunction

	// load one request; on the final one, walk the batch in service order
	function automatic void accept_request(input logic [15:0] trk, input logic fin);
		logic [15:0] srt [drs_pkg::MAX_REQ];
		logic [15:0] v;
		logic [16:0] tc;
		logic [16:0] d;
		logic [16:0] bestd;
		bit          served [drs_pkg::MAX_REQ];
		bit          found;
		bit          is_scan;
		int          j;
		int          lower;
		int          cnt;
		int          best;
		if (req_cnt < drs_pkg::MAX_REQ) begin
			req_store[req_cnt] = trk;
			req_cnt++;
		end
		if (!fin)
			return;
		head_pos = cfg_head;
		seek_sum = '0;
		cnt = req_cnt;
		if (cfg_alg == drs_pkg::ALG_SCAN || cfg_alg == drs_pkg::ALG_CLOOK) begin
			is_scan = (cfg_alg == drs_pkg::ALG_SCAN);
			for (int i = 0; i < cnt; i++) begin
				v = req_store[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			lower = 0;
			while (lower < cnt && srt[lower] <= head_pos)
				lower++;
			tc = (cfg_tcnt == '0) ? 17'd1 : cfg_tcnt;
			if (tc > (17'd1 << drs_pkg::TRACK_W))
				tc = 17'd1 << drs_pkg::TRACK_W;
			if (cfg_dir) begin
				for (int i = lower; i < cnt; i++)
					move_head(srt[i], 1'b0);
				if (is_scan) begin
					move_head(16'(tc - 17'd1), 1'b1);
					for (int i = lower - 1; i >= 0; i--)
						move_head(srt[i], 1'b0);
				end else begin
					for (int i = 0; i < lower; i++)
						move_head(srt[i], 1'b0);
				end
			end else begin
				for (int i = lower - 1; i >= 0; i--)
					move_head(srt[i], 1'b0);
				if (is_scan) begin
					move_head(16'd0, 1'b1);
					for (int i = lower; i < cnt; i++)
						move_head(srt[i], 1'b0);
				end else begin
					for (int i = cnt - 1; i >= lower; i--)
						move_head(srt[i], 1'b0);
				end
			end
		end else begin
			// nearest first; strict compare keeps the lowest load index on a tie
			for (int i = 0; i < cnt; i++)
				served[i] = 1'b0;
			for (int k = 0; k < cnt; k++) begin
				found = 1'b0;
				best = 0;
				bestd = '0;
				for (int i = 0; i < cnt; i++) begin
					d = (req_store[i] > head_pos) ? req_store[i] - head_pos
						: head_pos - req_store[i];
					if (!served[i] && (!found || d < bestd)) begin
						found = 1'b1;
						best = i;
						bestd = d;
					end
				end
				served[best] = 1'b1;
				move_head(req_store[best], 1'b0);
			end
		end
		expected_visits[expected_visits.size()-1].last = 1'b1;
		req_cnt = 0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// request driver: bursts of beats with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					nxt = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.trk;
					s_tlast <= nxt.fin;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern changes after a random hold
	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold--;
		end else begin
			case ($urandom_range(0, 2))
				0: rdy_mode = RDY_FULL;
				1: rdy_mode = RDY_COIN;
				default: rdy_mode = RDY_SPARSE;
			endcase
			rdy_hold = $urandom_range(10, 150);
		end
		case (rdy_mode)
			RDY_FULL: m_tready <= 1'b1;
			RDY_COIN: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// monitor: predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accept_request(s_tdata, s_tlast);
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_visits.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat: expected none, actual %0h %b %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					exp_v = expected_visits.pop_front();
					check_field("served_position", 32'(exp_v.pos), 32'(m_tdata[15:0]));
					check_field("distance_so_far", 32'(exp_v.seek), 32'(m_tdata[37:16]));
					check_field("tdata pad", 32'd0, 32'(m_tdata[39:38]));
					check_field("is_disk_end", 32'(exp_v.at_end), 32'(m_tuser));
					check_field("last_result", 32'(exp_v.last), 32'(m_tlast));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("FAIL disk_request_scheduler_unit");
		$finish;
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			drs_pkg::REG_ALG:  cfg_alg = val[1:0];
			drs_pkg::REG_DIR:  cfg_dir = val[0];
			drs_pkg::REG_TCNT: cfg_tcnt = val[16:0];
			default:           cfg_head = val[15:0];
		endcase
	endtask

	task automatic write_config(input logic [1:0] alg, input logic dir,
			input logic [16:0] tcnt, input logic [15:0] hd);
		reg_write(drs_pkg::REG_ALG, 32'(alg));
		reg_write(drs_pkg::REG_DIR, 32'(dir));
		reg_write(drs_pkg::REG_TCNT, 32'(tcnt));
		reg_write(drs_pkg::REG_SHEAD, 32'(hd));
	endtask

	task automatic push_req(input logic [15:0] trk, input logic fin);
		req_beat_t b;
		b.trk = trk;
		b.fin = fin;
		req_queue.push_back(b);
		pushed_cnt++;
	endtask

	// block is idle once every beat is in and every result is out
	task automatic wait_idle();
		while (req_queue.size() != 0 || accepted_cnt != pushed_cnt
				|| expected_visits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	initial begin
		int          nb;
		int          len;
		int          target;
		logic [1:0]  alg;
		logic        dir;
		logic [16:0] tcnt;
		logic [15:0] hd;
		logic [15:0] trk;
		logic [15:0] prev_trk;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// SSTF, equal distances on both sides, both track extremes
		write_config(drs_pkg::ALG_SSTF, 1'b1, 17'd65536, 16'd1000);
		push_req(16'd1100, 1'b0);
		push_req(16'd900, 1'b0);
		push_req(16'hFFFF, 1'b0);
		push_req(16'd0, 1'b0);
		push_req(16'd1000, 1'b1);
		wait_idle();

		// SCAN upward, request equal to head belongs to the lower group
		write_config(drs_pkg::ALG_SCAN, 1'b1, 17'd65536, 16'd500);
		push_req(16'd700, 1'b0);
		push_req(16'd200, 1'b0);
		push_req(16'd500, 1'b0);
		push_req(16'hFFFF, 1'b1);
		wait_idle();

		// SCAN downward with nothing below the head, smallest disk
		write_config(drs_pkg::ALG_SCAN, 1'b0, 17'd1, 16'd0);
		push_req(16'd5, 1'b0);
		push_req(16'd3, 1'b1);
		wait_idle();

		// SCAN upward with nothing above the head, track count zero
		write_config(drs_pkg::ALG_SCAN, 1'b1, 17'd0, 16'hFFFF);
		push_req(16'd10, 1'b0);
		push_req(16'hFFFF, 1'b1);
		wait_idle();

		// C-LOOK both ways, oversized track count
		write_config(drs_pkg::ALG_CLOOK, 1'b1, 17'h1FFFF, 16'd300);
		push_req(16'd100, 1'b0);
		push_req(16'd400, 1'b0);
		push_req(16'd200, 1'b0);
		push_req(16'd500, 1'b1);
		wait_idle();
		write_config(drs_pkg::ALG_CLOOK, 1'b0, 17'd65536, 16'd300);
		push_req(16'd100, 1'b0);
		push_req(16'd400, 1'b0);
		push_req(16'd200, 1'b0);
		push_req(16'd500, 1'b1);
		wait_idle();

		// unused algorithm code, single-request batch
		write_config(2'd3, 1'b0, 17'd65536, 16'hFFFF);
		push_req(16'd0, 1'b1);
		wait_idle();

		target = pushed_cnt + RAND_ITEMS;
		prev_trk = '0;
		while (pushed_cnt < target) begin
			alg = 2'($urandom_range(0, 3));
			dir = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: tcnt = 17'd0;
				1: tcnt = 17'd1;
				2: tcnt = 17'd2;
				3: tcnt = 17'd65535;
				4: tcnt = 17'd65536;
				5: tcnt = 17'($urandom_range(65537, 131071));
				default: tcnt = 17'($urandom_range(1, 65536));
			endcase
			case ($urandom_range(0, 3))
				0: hd = 16'd0;
				1: hd = 16'hFFFF;
				default: hd = 16'($urandom);
			endcase
			write_config(alg, dir, tcnt, hd);
			nb = $urandom_range(1, 3);
			repeat (nb) begin
				// mostly short batches, now and then a long one that can overfill the store
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
					: $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 5))
						0: trk = 16'd0;
						1: trk = 16'hFFFF;
						2: trk = cfg_head + 16'($urandom_range(0, 8)) - 16'd4;
						3: trk = prev_trk;
						default: trk = 16'($urandom);
					endcase
					prev_trk = trk;
					push_req(trk, i == len - 1);
				end
			end
			wait_idle();
		end

		if (errors == 0 && expected_visits.size() == 0)
			$display("PASS disk_request_scheduler_unit");
		else
			$display("FAIL disk_request_scheduler_unit");
		$finish;
	end

endmodule
